FILE: rtl/rta_pkg.sv
// shared types and codes for the route table with aging
package rta_pkg;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_RREQ    = 2'd0;
  localparam logic [1:0] KIND_RREP    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  localparam logic [31:0] TIMEOUT_RESET = 32'd20;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] dest_addr;
    logic [47:0] next_hop_mac;
    logic [7:0]  hops;
    logic [7:0]  iface;
    logic        force_discovery;
    logic [1:0]  packet_kind;
    logic [30:0] bcast_id;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        stale_dropped;
    logic        written;
    logic        table_full;
    logic [47:0] out_mac;
    logic [7:0]  out_hops;
    logic [7:0]  out_iface;
    logic [30:0] out_bcast_id;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [47:0] mac;
    logic [7:0]  hops;
    logic [7:0]  iface;
    logic [30:0] bcast;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_full;
  } dp_sts_t;

endpackage

FILE: rtl/rta_ram.sv
// generic single write port ram with registered read
module rta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/rta_ctrl.sv
// sequencing state machine for the route table
module rta_ctrl import rta_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.commit = (state_r == ST_DECIDE) && !sts.out_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts.out_full) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/rta_dp.sv
// route table datapath: slot store, scan compare, decision and result register
module rta_dp import rta_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  in_item_t    in_data,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_data,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [31:0]              timeout_r, timeout_nxt;
  logic [31:0]              now_r, now_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]         cnt_r, cnt_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]         chk_idx_r, chk_idx_nxt;
  logic                     match_r, match_nxt;
  logic                     stale_r, stale_nxt;
  logic [IDX_W-1:0]         match_idx_r, match_idx_nxt;
  entry_t                   ent_r, ent_nxt;
  logic                     free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  in_item_t                 item_r, item_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  entry_t           rd_ent;
  entry_t           new_ent;
  logic             forced;
  logic             skip_scan;
  logic             key_eq;
  logic [31:0]      age;
  logic             fresh;
  logic             scan_done;
  logic             better;
  logic             ins_ok;
  logic [IDX_W-1:0] ins_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             clr_en;
  logic             set_en;
  out_item_t        res;

  rta_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_slots (
    .clk     (clk),
    .wr_en   (cmd.commit && wr_en),
    .wr_addr (wr_idx),
    .wr_data (new_ent),
    .rd_addr (cnt_r),
    .rd_data (rd_ent)
  );

  // scan compare on the slot read last cycle
  assign forced = item_r.force_discovery &&
                  (item_r.packet_kind == KIND_RREQ || item_r.packet_kind == KIND_PAYLOAD);
  assign skip_scan = (item_r.command == CMD_LOOKUP && forced) ||
                     (item_r.command != CMD_LOOKUP && item_r.command != CMD_UPDATE);
  assign key_eq    = chk_vld_r && valid_r[chk_idx_r] && (rd_ent.key == item_r.dest_addr);
  assign age       = now_r - rd_ent.stamp;
  assign fresh     = (age < timeout_r);
  assign scan_done = skip_scan || (chk_vld_r && (key_eq || chk_idx_r == LAST_IDX));

  assign sts.scan_done = scan_done;
  assign sts.out_full  = out_valid_r && !out_ready;

  // decision on the scan outcome
  always_comb begin
    new_ent.key   = item_r.dest_addr;
    new_ent.mac   = item_r.next_hop_mac;
    new_ent.hops  = item_r.hops;
    new_ent.iface = item_r.iface;
    new_ent.bcast = item_r.bcast_id;
    new_ent.stamp = now_r;
    better  = (item_r.bcast_id > ent_r.bcast) ||
              (item_r.bcast_id == ent_r.bcast && item_r.hops < ent_r.hops);
    ins_ok  = free_vld_r || (match_r && stale_r);
    ins_idx = free_vld_r ? free_idx_r : match_idx_r;
    res     = '0;
    wr_en   = 1'b0;
    wr_idx  = match_idx_r;
    clr_en  = 1'b0;
    set_en  = 1'b0;
    unique case (item_r.command)
      CMD_LOOKUP: begin
        if (!forced) begin
          res.stale_dropped = match_r && stale_r;
          clr_en            = match_r && stale_r;
          if (match_r && !stale_r) begin
            res.hit          = 1'b1;
            res.out_mac      = ent_r.mac;
            res.out_hops     = ent_r.hops;
            res.out_iface    = ent_r.iface;
            res.out_bcast_id = ent_r.bcast;
          end
        end
      end
      CMD_UPDATE: begin
        res.stale_dropped = match_r && stale_r;
        clr_en            = match_r && stale_r;
        if (match_r && !stale_r) begin
          res.hit = 1'b1;
          if (better) begin
            wr_en            = 1'b1;
            res.written      = 1'b1;
            res.out_mac      = item_r.next_hop_mac;
            res.out_hops     = item_r.hops;
            res.out_iface    = item_r.iface;
            res.out_bcast_id = item_r.bcast_id;
          end else begin
            res.out_mac      = ent_r.mac;
            res.out_hops     = ent_r.hops;
            res.out_iface    = ent_r.iface;
            res.out_bcast_id = ent_r.bcast;
          end
        end else if (ins_ok) begin
          // lowest free slot, possibly the one just dropped
          wr_en            = 1'b1;
          wr_idx           = ins_idx;
          set_en           = 1'b1;
          res.written      = 1'b1;
          res.out_mac      = item_r.next_hop_mac;
          res.out_hops     = item_r.hops;
          res.out_iface    = item_r.iface;
          res.out_bcast_id = item_r.bcast_id;
        end else begin
          res.table_full = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    timeout_nxt   = cfg_wr_en ? cfg_wr_data : timeout_r;
    now_nxt       = now_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    match_nxt     = match_r;
    stale_nxt     = stale_r;
    match_idx_nxt = match_idx_r;
    ent_nxt       = ent_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cmd.load) begin
      item_nxt     = in_data;
      cnt_nxt      = '0;
      chk_vld_nxt  = 1'b0;
      match_nxt    = 1'b0;
      free_vld_nxt = 1'b0;
    end

    if (cmd.scan && !skip_scan) begin
      cnt_nxt     = (cnt_r == LAST_IDX) ? cnt_r : cnt_r + IDX_W'(1);
      chk_vld_nxt = !scan_done;
      chk_idx_nxt = cnt_r;
      if (key_eq) begin
        match_nxt     = 1'b1;
        stale_nxt     = !fresh;
        match_idx_nxt = chk_idx_r;
        ent_nxt       = rd_ent;
      end
      if (chk_vld_r && !valid_r[chk_idx_r] && !free_vld_r) begin
        free_vld_nxt = 1'b1;
        free_idx_nxt = chk_idx_r;
      end
    end

    if (cmd.commit) begin
      if (item_r.command == CMD_TICK) now_nxt = now_r + 32'd1;
      if (clr_en) valid_nxt[match_idx_r] = 1'b0;
      if (set_en) valid_nxt[ins_idx] = 1'b1;
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      now_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      match_r     <= 1'b0;
      free_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      timeout_r   <= timeout_nxt;
      now_r       <= now_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      match_r     <= match_nxt;
      free_vld_r  <= free_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r   <= chk_idx_nxt;
    stale_r     <= stale_nxt;
    match_idx_r <= match_idx_nxt;
    ent_r       <= ent_nxt;
    free_idx_r  <= free_idx_nxt;
    item_r      <= item_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/route_table_with_aging.sv
// top level of the route table with aging
// lookup and update: the scan reads one slot per cycle through the slot ram read port
//   and stops at the first match
// tick and forced lookup skip the scan; result valid the cycle after the decision
// the next item is taken while a result still waits in the output register
// reset (synchronous, active low): all slots invalid, tick counter zero, timeout 20,
//   no clearing pass, the block is ready right after reset
module route_table_with_aging import rta_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  // command and status between the sequencer and the datapath
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer: idle, scan, decide
  rta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot store, valid bits, tick counter, timeout register and result register
  rta_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  // one item in flight: an accepted item closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a decision never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  // a fresh hit excludes a stale drop and a full table
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> (!out_data.stale_dropped && !out_data.table_full))
    else $error("hit together with stale drop or full table");

  // a dropped insertion reports nothing written and no entry
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_full) |-> (!out_data.written && out_data.out_mac == 48'd0))
    else $error("full table result carries entry data");

endmodule
